// File: hw/rtl/gregorian_date_offset_assert.svh
// Assertion macros shared by the date offset checker
`ifndef GREGORIAN_DATE_OFFSET_ASSERT_SVH
`define GREGORIAN_DATE_OFFSET_ASSERT_SVH

// hold expr true at every clock edge outside reset
`define GDO_ASSERT_ALWAYS(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// hold cons true in the cycle after ante
`define GDO_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hw/rtl/gdo_pkg.sv
// Shared types, constants and calendar functions for the date offset block
`default_nettype none

package gdo_pkg;

    localparam int COUNT_BITS = 16;

    localparam logic [13:0] YEAR_MIN = 14'd1;
    localparam logic [13:0] YEAR_MAX = 14'd9999;
    localparam logic [3:0]  MONTH_FIRST = 4'd1;
    localparam logic [3:0]  MONTH_LAST = 4'd12;
    localparam logic [4:0]  DAY_FIRST = 5'd1;
    localparam logic [4:0]  DAY_LAST_DEC = 5'd31;
    localparam logic [6:0]  CENTURY_LAST = 7'd99;

    localparam logic [28:0] DIV100_MUL = 29'd5243;
    localparam int          DIV100_SHIFT = 19;

    localparam logic OP_FORWARD = 1'b0;
    localparam logic OP_BACKWARD = 1'b1;

    typedef logic [COUNT_BITS-1:0] count_t;

    typedef struct packed {
        logic load;
        logic divide;
        logic split;
        logic clamp;
        logic step;
        logic capture;
    } cmd_t;

    typedef struct packed {
        logic done;
    } status_t;

    localparam logic [4:0] MONTH_LEN [12] = '{
        5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
        5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
    };

    function automatic logic is_leap(input logic [6:0] century, input logic [6:0] rem);
        return (rem[1:0] == 2'd0) && ((rem != 7'd0) || (century[1:0] == 2'd0));
    endfunction

    function automatic logic [4:0] days_in(input logic [3:0] month, input logic leap);
        logic [3:0] idx;
        idx = month - 4'd1;
        if (month == 4'd2 && leap)
            return 5'd29;
        return MONTH_LEN[idx];
    endfunction

endpackage

`default_nettype wire

// File: hw/rtl/gdo_datapath.sv
// Datapath: date registers, century split, day stepper and result register
`default_nettype none

module gdo_datapath (
    input  wire logic           clk,
    input  wire gdo_pkg::cmd_t  cmd,
    output gdo_pkg::status_t    status,
    input  wire logic           op,
    input  wire logic [13:0]    start_year,
    input  wire logic [3:0]     start_month,
    input  wire logic [4:0]     start_day,
    input  wire logic [15:0]    day_count,
    output logic [13:0]         result_year,
    output logic [3:0]          result_month,
    output logic [4:0]          result_day,
    output logic                out_of_range
);

    logic             op_reg;
    logic [13:0]      year_reg, year_next;
    logic [3:0]       month_reg, month_next;
    logic [4:0]       day_reg, day_next;
    gdo_pkg::count_t  count_reg, count_next;
    logic             flag_reg, flag_next;
    logic [6:0]       hi_reg, hi_next;
    logic [6:0]       lo_reg, lo_next;
    logic [13:0]      res_year_reg;
    logic [3:0]       res_month_reg;
    logic [4:0]       res_day_reg;
    logic             res_flag_reg;

    logic [28:0]      quot_prod;
    logic             leap;
    logic [4:0]       cur_len;
    logic [4:0]       prev_len;
    logic             at_edge;
    logic [13:0]      clamp_year;
    logic [3:0]       clamp_month;
    logic [4:0]       clamp_day;

    assign quot_prod = 29'(year_reg) * gdo_pkg::DIV100_MUL;
    assign leap      = gdo_pkg::is_leap(hi_reg, lo_reg);
    assign cur_len   = gdo_pkg::days_in(month_reg, leap);
    assign prev_len  = gdo_pkg::days_in(month_reg - 4'd1, leap);
    assign at_edge   = (op_reg == gdo_pkg::OP_FORWARD)
                     ? (year_reg == gdo_pkg::YEAR_MAX && month_reg == gdo_pkg::MONTH_LAST
                        && day_reg == gdo_pkg::DAY_LAST_DEC)
                     : (year_reg == gdo_pkg::YEAR_MIN && month_reg == gdo_pkg::MONTH_FIRST
                        && day_reg == gdo_pkg::DAY_FIRST);

    assign status.done = (count_reg == '0) || flag_reg;

    always_comb
    begin
        clamp_year = start_year;
        if (start_year < gdo_pkg::YEAR_MIN)
            clamp_year = gdo_pkg::YEAR_MIN;
        else if (start_year > gdo_pkg::YEAR_MAX)
            clamp_year = gdo_pkg::YEAR_MAX;
        clamp_month = start_month;
        if (start_month < gdo_pkg::MONTH_FIRST)
            clamp_month = gdo_pkg::MONTH_FIRST;
        else if (start_month > gdo_pkg::MONTH_LAST)
            clamp_month = gdo_pkg::MONTH_LAST;
        clamp_day = (start_day < gdo_pkg::DAY_FIRST) ? gdo_pkg::DAY_FIRST : start_day;
    end

    always_comb
    begin
        year_next  = year_reg;
        month_next = month_reg;
        day_next   = day_reg;
        count_next = count_reg;
        flag_next  = flag_reg;
        hi_next    = hi_reg;
        lo_next    = lo_reg;
        priority if (cmd.load)
        begin
            year_next  = clamp_year;
            month_next = clamp_month;
            day_next   = clamp_day;
            count_next = gdo_pkg::count_t'(day_count);
            flag_next  = 1'b0;
        end
        else if (cmd.divide)
        begin
            hi_next = quot_prod[gdo_pkg::DIV100_SHIFT +: 7];
        end
        else if (cmd.split)
        begin
            lo_next = 7'(year_reg - 14'(hi_reg) * 14'd100);
        end
        else if (cmd.clamp)
        begin
            if (day_reg > cur_len)
                day_next = cur_len;
        end
        else if (cmd.step)
        begin
            if (at_edge)
                flag_next = 1'b1;
            else
            begin
                count_next = count_reg - gdo_pkg::count_t'(1);
                if (op_reg == gdo_pkg::OP_FORWARD)
                begin
                    if (day_reg == cur_len)
                    begin
                        day_next = gdo_pkg::DAY_FIRST;
                        if (month_reg == gdo_pkg::MONTH_LAST)
                        begin
                            month_next = gdo_pkg::MONTH_FIRST;
                            year_next  = year_reg + 14'd1;
                            if (lo_reg == gdo_pkg::CENTURY_LAST)
                            begin
                                lo_next = 7'd0;
                                hi_next = hi_reg + 7'd1;
                            end
                            else
                                lo_next = lo_reg + 7'd1;
                        end
                        else
                            month_next = month_reg + 4'd1;
                    end
                    else
                        day_next = day_reg + 5'd1;
                end
                else
                begin
                    if (day_reg == gdo_pkg::DAY_FIRST)
                    begin
                        if (month_reg == gdo_pkg::MONTH_FIRST)
                        begin
                            month_next = gdo_pkg::MONTH_LAST;
                            day_next   = gdo_pkg::DAY_LAST_DEC;
                            year_next  = year_reg - 14'd1;
                            if (lo_reg == 7'd0)
                            begin
                                lo_next = gdo_pkg::CENTURY_LAST;
                                hi_next = hi_reg - 7'd1;
                            end
                            else
                                lo_next = lo_reg - 7'd1;
                        end
                        else
                        begin
                            month_next = month_reg - 4'd1;
                            day_next   = prev_len;
                        end
                    end
                    else
                        day_next = day_reg - 5'd1;
                end
            end
        end
        else
        begin
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            op_reg <= op;
        year_reg  <= year_next;
        month_reg <= month_next;
        day_reg   <= day_next;
        count_reg <= count_next;
        flag_reg  <= flag_next;
        hi_reg    <= hi_next;
        lo_reg    <= lo_next;
        if (cmd.capture)
        begin
            res_year_reg  <= year_reg;
            res_month_reg <= month_reg;
            res_day_reg   <= day_reg;
            res_flag_reg  <= flag_reg;
        end
    end

    assign result_year  = res_year_reg;
    assign result_month = res_month_reg;
    assign result_day   = res_day_reg;
    assign out_of_range = res_flag_reg;

endmodule

`default_nettype wire

// File: hw/rtl/gdo_controller.sv
// Controller: sequences load, century split, day clamp, stepping and result handoff
`default_nettype none

module gdo_controller (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             req_valid,
    output logic                  req_stall,
    output logic                  rsp_valid,
    input  wire logic             rsp_stall,
    output gdo_pkg::cmd_t         cmd,
    input  wire gdo_pkg::status_t status
);

    typedef enum logic [5:0] {
        ST_IDLE   = 6'b000001,
        ST_DIVIDE = 6'b000010,
        ST_SPLIT  = 6'b000100,
        ST_CLAMP  = 6'b001000,
        ST_STEP   = 6'b010000,
        ST_FINISH = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   out_free;

    assign out_free  = !rsp_valid_reg || !rsp_stall;
    assign req_stall = (state_reg != ST_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        cmd            = '0;
        rsp_valid_next = rsp_valid_reg && rsp_stall;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (req_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                cmd.divide = 1'b1;
                state_next = ST_SPLIT;
            end
            ST_SPLIT:
            begin
                cmd.split  = 1'b1;
                state_next = ST_CLAMP;
            end
            ST_CLAMP:
            begin
                cmd.clamp  = 1'b1;
                state_next = ST_STEP;
            end
            ST_STEP:
            begin
                if (status.done)
                    state_next = ST_FINISH;
                else
                    cmd.step = 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    cmd.capture    = 1'b1;
                    rsp_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

endmodule

`default_nettype wire

// File: hw/rtl/gregorian_date_offset.sv
// Steps one day per cycle in the datapath stepper; setup steps through divide, split and clamp.
// A new request is taken in idle; the result register frees the input side while a result waits.
// Reset: rst_n asynchronous active low clears controller state and result valid.
// Top level: Gregorian date add/subtract days
`default_nettype none

module gregorian_date_offset (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        req_valid,
    output logic             req_stall,
    input  wire logic        op,
    input  wire logic [13:0] start_year,
    input  wire logic [3:0]  start_month,
    input  wire logic [4:0]  start_day,
    input  wire logic [15:0] day_count,
    output logic             rsp_valid,
    input  wire logic        rsp_stall,
    output logic [13:0]      result_year,
    output logic [3:0]       result_month,
    output logic [4:0]       result_day,
    output logic             out_of_range
);

    gdo_pkg::cmd_t    cmd;
    gdo_pkg::status_t status;

    gdo_controller u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_stall (req_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .cmd       (cmd),
        .status    (status)
    );

    gdo_datapath u_dp (
        .clk          (clk),
        .cmd          (cmd),
        .status       (status),
        .op           (op),
        .start_year   (start_year),
        .start_month  (start_month),
        .start_day    (start_day),
        .day_count    (day_count),
        .result_year  (result_year),
        .result_month (result_month),
        .result_day   (result_day),
        .out_of_range (out_of_range)
    );

endmodule

`default_nettype wire

// File: hw/rtl/gdo_checker.sv
// Port-level checker for the date offset block and its bind
`default_nettype none

`include "gregorian_date_offset_assert.svh"

module gdo_checker (
    input wire logic        clk,
    input wire logic        rst_n,
    input wire logic        req_valid,
    input wire logic        req_stall,
    input wire logic        rsp_valid,
    input wire logic        rsp_stall,
    input wire logic [13:0] result_year,
    input wire logic [3:0]  result_month,
    input wire logic [4:0]  result_day,
    input wire logic        out_of_range
);

    logic        req_take;
    logic        rsp_wait;
    logic [24:0] rsp_word;
    logic        date_legal;
    logic        at_bound;

    assign req_take   = req_valid && !req_stall;
    assign rsp_wait   = rsp_valid && rsp_stall;
    assign rsp_word   = {rsp_valid, result_year, result_month, result_day, out_of_range};
    assign date_legal = (result_year >= gdo_pkg::YEAR_MIN) && (result_year <= gdo_pkg::YEAR_MAX)
                     && (result_month >= gdo_pkg::MONTH_FIRST)
                     && (result_month <= gdo_pkg::MONTH_LAST)
                     && (result_day >= gdo_pkg::DAY_FIRST)
                     && (result_day <= gdo_pkg::DAY_LAST_DEC);
    assign at_bound   = (result_year == gdo_pkg::YEAR_MAX && result_month == gdo_pkg::MONTH_LAST
                         && result_day == gdo_pkg::DAY_LAST_DEC)
                     || (result_year == gdo_pkg::YEAR_MIN && result_month == gdo_pkg::MONTH_FIRST
                         && result_day == gdo_pkg::DAY_FIRST);

    `GDO_ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_wait, $stable(rsp_word), "stalled result changed")
    `GDO_ASSERT_NEXT(a_busy_after_req, clk, rst_n, req_take, req_stall, "input open after request")
    `GDO_ASSERT_ALWAYS(a_date_legal, clk, rst_n, !rsp_valid || date_legal, "result date out of span")
    `GDO_ASSERT_ALWAYS(a_flag_edge, clk, rst_n, !rsp_valid || !out_of_range || at_bound, "flag off edge")

endmodule

bind gregorian_date_offset gdo_checker u_gdo_checker (.*);

`default_nettype wire
